### hdl/qtus_pkg.sv
// Shared constants, configuration layout and controller/datapath interface types.
package qtus_pkg;

    localparam int NUM_ENVS    = 4;
    localparam int MAX_STATES  = 256;
    localparam int MAX_ACTIONS = 8;

    localparam int STORE_DEPTH = NUM_ENVS * MAX_STATES * MAX_ACTIONS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int ACT_W       = (MAX_ACTIONS > 1) ? $clog2(MAX_ACTIONS) : 1;
    localparam int NA_W        = $clog2(MAX_ACTIONS + 1);
    localparam int NS_W        = $clog2(MAX_STATES + 1);

    // fixed field widths
    localparam int ENV_W    = 2;
    localparam int STATE_W  = 8;
    localparam int ACTION_W = 3;
    localparam int Q_W      = 32;
    localparam int FRAC_W   = 17;
    localparam int DRAW_W   = 16;
    localparam int GRID_W   = 5;
    localparam int NACT_W   = 4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int ONE_Q16    = 65536;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_SELECT = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_WIDTH   = 3'd0,
        CFG_GRID_HEIGHT  = 3'd1,
        CFG_ACTIONS      = 3'd2,
        CFG_LEARN_RATE   = 3'd3,
        CFG_DISCOUNT     = 3'd4,
        CFG_EXPLORE      = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [GRID_W-1:0] grid_cols;
        logic [GRID_W-1:0] grid_rows;
        logic [NACT_W-1:0] actions_in_use;
        logic [FRAC_W-1:0] alpha_rate;
        logic [FRAC_W-1:0] discount;
        logic [FRAC_W-1:0] explore_threshold;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_CUR,
        ST_SEL_LAST,
        ST_MUL1,
        ST_SUM1,
        ST_DIFF,
        ST_MUL2,
        ST_SUM2,
        ST_FINISH
    } ctrl_state_t;

    typedef enum logic [1:0] {
        RES_REJECT,
        RES_RANDOM,
        RES_GREEDY,
        RES_UPDATE
    } res_kind_t;

    typedef struct packed {
        logic      clr_we;
        logic      load_in;
        logic      cnt_clr;
        logic      cnt_inc;
        logic      rd_en;
        logic      rd_cur;
        logic      cmp_en;
        logic      mul1;
        logic      sum1;
        logic      diff;
        logic      mul2;
        logic      sum2;
        logic      out_load;
        logic      q_we;
        res_kind_t res_kind;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic op_select;
        logic env_bad;
        logic upd_bad;
        logic sel_bad;
        logic explore;
        logic scan_last;
        logic out_busy;
    } dp_stat_t;

endpackage

### hdl/qtus_dpath.sv
// Datapath: Q table memory, max/argmax scan, fixed-point update and result register.
module qtus_dpath import qtus_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  cfg_t                     cfg,
    input  dp_cmd_t                  cmd,
    output dp_stat_t                 stat,
    input  logic                     s_opcode,
    input  logic [ENV_W-1:0]         s_env_index,
    input  logic [STATE_W-1:0]       s_cur_state,
    input  logic [ACTION_W-1:0]      s_taken_action,
    input  logic [STATE_W-1:0]       s_following_state,
    input  logic signed [Q_W-1:0]    s_reward_value,
    input  logic [DRAW_W-1:0]        s_random_draw,
    input  logic [ACTION_W-1:0]      s_random_choice,
    input  logic                     m_ready,
    output logic                     m_valid,
    output logic [ACTION_W-1:0]      m_chosen_action,
    output logic signed [Q_W-1:0]    m_written_value,
    output logic                     m_explored,
    output logic                     m_status
);

    localparam int P1_W = Q_W + FRAC_W + 1;
    localparam int P2_W = Q_W + FRAC_W + 2;

    function automatic logic [ADDR_W-1:0] q_addr(input logic [ENV_W-1:0] env,
                                                 input logic [STATE_W-1:0] st,
                                                 input logic [ACT_W-1:0] act);
        return ADDR_W'((32'(env) * MAX_STATES + 32'(st)) * MAX_ACTIONS + 32'(act));
    endfunction

    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sd2147483647;
        lo = -64'sd2147483648;
        if (v > hi) begin
            return Q_W'(hi);
        end else if (v < lo) begin
            return Q_W'(lo);
        end
        return Q_W'(v);
    endfunction

    // random action modulo actions in use, by repeated subtraction
    function automatic logic [ACTION_W-1:0] act_mod(input logic [ACTION_W-1:0] r_in,
                                                    input logic [NA_W-1:0] n_in);
        logic [4:0] r;
        logic [4:0] n;
        r = 5'(r_in);
        n = 5'(n_in);
        for (int i = 0; i < 8; i++) begin
            if (r >= n) begin
                r = r - n;
            end
        end
        return ACTION_W'(r);
    endfunction

    // latched input word
    logic                  op_reg;
    logic [ENV_W-1:0]      env_reg;
    logic [STATE_W-1:0]    st_reg;
    logic [ACTION_W-1:0]   act_reg;
    logic [STATE_W-1:0]    nst_reg;
    logic signed [Q_W-1:0] reward_reg;
    logic [DRAW_W-1:0]     draw_reg;
    logic [ACTION_W-1:0]   rch_reg;

    logic signed [Q_W-1:0] q_mem [STORE_DEPTH];
    logic signed [Q_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0]     clr_addr_reg;
    logic [ACT_W-1:0]      cnt_reg;
    logic                  cmp_valid_reg;
    logic [ACT_W-1:0]      cmp_idx_reg;
    logic signed [Q_W-1:0] best_reg;
    logic [ACT_W-1:0]      best_idx_reg;
    logic signed [Q_W-1:0] cur_reg;
    logic signed [P1_W-1:0] p1_reg;
    logic signed [Q_W-1:0] target_reg;
    logic signed [Q_W:0]   diff_reg;
    logic signed [P2_W-1:0] p2_reg;
    logic signed [Q_W-1:0] nq_reg;

    logic                  m_valid_reg;
    logic [ACTION_W-1:0]   chosen_reg;
    logic signed [Q_W-1:0] written_reg;
    logic                  explored_reg;
    logic                  status_reg;

    logic [2*GRID_W-1:0]   grid_cells;
    logic [NS_W-1:0]       ns_eff;
    logic [NA_W-1:0]       na_eff;
    logic [FRAC_W-1:0]     gamma_eff;
    logic [FRAC_W-1:0]     lr_eff;
    logic                  st_ok;
    logic                  nst_ok;
    logic                  act_ok;
    logic [STATE_W-1:0]    scan_st;
    logic [ADDR_W-1:0]     rd_addr;
    logic [ADDR_W-1:0]     upd_addr;
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_wa;
    logic signed [Q_W-1:0] mem_wd;
    logic                  cmp_take;
    logic signed [P1_W-1:0] p1_next;
    logic signed [63:0]    rnd1;
    logic signed [Q_W:0]   diff_next;
    logic signed [P2_W-1:0] p2_next;
    logic signed [63:0]    rnd2;

    // effective configuration
    always_comb begin
        grid_cells = (2*GRID_W)'(cfg.grid_cols) * (2*GRID_W)'(cfg.grid_rows);
        ns_eff     = (32'(grid_cells) > MAX_STATES) ? NS_W'(MAX_STATES) : NS_W'(grid_cells);
        if (cfg.actions_in_use == '0) begin
            na_eff = NA_W'(1);
        end else if (32'(cfg.actions_in_use) > MAX_ACTIONS) begin
            na_eff = NA_W'(MAX_ACTIONS);
        end else begin
            na_eff = NA_W'(cfg.actions_in_use);
        end
        gamma_eff = (32'(cfg.discount) > ONE_Q16) ? FRAC_W'(ONE_Q16) : cfg.discount;
        lr_eff    = (32'(cfg.alpha_rate) > ONE_Q16) ? FRAC_W'(ONE_Q16) : cfg.alpha_rate;
    end

    always_comb begin
        st_ok  = 32'(st_reg) < 32'(ns_eff);
        nst_ok = 32'(nst_reg) < 32'(ns_eff);
        act_ok = 32'(act_reg) < 32'(na_eff);

        stat.clr_done  = 32'(clr_addr_reg) == STORE_DEPTH - 1;
        stat.op_select = (op_reg == OP_SELECT);
        stat.env_bad   = 32'(env_reg) >= NUM_ENVS;
        stat.upd_bad   = !st_ok || !nst_ok || !act_ok;
        stat.sel_bad   = !st_ok;
        stat.explore   = 32'(draw_reg) < 32'(cfg.explore_threshold);
        stat.scan_last = 32'(cnt_reg) == 32'(na_eff) - 1;
        stat.out_busy  = m_valid_reg && !m_ready;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg     <= s_opcode;
            env_reg    <= s_env_index;
            st_reg     <= s_cur_state;
            act_reg    <= s_taken_action;
            nst_reg    <= s_following_state;
            reward_reg <= s_reward_value;
            draw_reg   <= s_random_draw;
            rch_reg    <= s_random_choice;
        end
    end

    // table memory: one write port, one registered read port
    always_comb begin
        scan_st  = (op_reg == OP_SELECT) ? st_reg : nst_reg;
        upd_addr = q_addr(env_reg, st_reg, ACT_W'(act_reg));
        rd_addr  = cmd.rd_cur ? upd_addr : q_addr(env_reg, scan_st, cnt_reg);
        mem_we   = cmd.clr_we || cmd.q_we;
        mem_wa   = cmd.clr_we ? clr_addr_reg : upd_addr;
        mem_wd   = cmd.clr_we ? '0 : nq_reg;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            q_mem[mem_wa] <= mem_wd;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= q_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clr_we) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    // scan counter and running max; the first action always seeds the max
    always_ff @(posedge aclk) begin
        if (cmd.cnt_clr) begin
            cnt_reg <= '0;
        end else if (cmd.cnt_inc) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
        cmp_idx_reg <= cnt_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmp_valid_reg <= 1'b0;
        end else begin
            cmp_valid_reg <= cmd.cmp_en;
        end
    end

    assign cmp_take = cmp_valid_reg && (cmp_idx_reg == '0 || rd_data_reg > best_reg);

    always_ff @(posedge aclk) begin
        if (cmp_take) begin
            best_reg     <= rd_data_reg;
            best_idx_reg <= cmp_idx_reg;
        end
    end

    // update arithmetic, one multiply or one wide add per cycle
    always_comb begin
        p1_next   = P1_W'(best_reg) * P1_W'($signed({1'b0, gamma_eff}));
        rnd1      = 64'((p1_reg + P1_W'(32768)) >>> 16);
        diff_next = (Q_W+1)'(target_reg) - (Q_W+1)'(cur_reg);
        p2_next   = P2_W'(diff_reg) * P2_W'($signed({1'b0, lr_eff}));
        rnd2      = 64'((p2_reg + P2_W'(32768)) >>> 16);
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul1) begin
            cur_reg <= rd_data_reg;
            p1_reg  <= p1_next;
        end
        if (cmd.sum1) begin
            target_reg <= sat_q(64'(reward_reg) + rnd1);
        end
        if (cmd.diff) begin
            diff_reg <= diff_next;
        end
        if (cmd.mul2) begin
            p2_reg <= p2_next;
        end
        if (cmd.sum2) begin
            nq_reg <= sat_q(64'(cur_reg) + rnd2);
        end
    end

    // result register: hold the word until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            unique case (cmd.res_kind)
                RES_REJECT: begin
                    chosen_reg   <= '0;
                    written_reg  <= '0;
                    explored_reg <= 1'b0;
                    status_reg   <= 1'b1;
                end
                RES_RANDOM: begin
                    chosen_reg   <= act_mod(rch_reg, na_eff);
                    written_reg  <= '0;
                    explored_reg <= 1'b1;
                    status_reg   <= stat.sel_bad;
                end
                RES_GREEDY: begin
                    chosen_reg   <= ACTION_W'(best_idx_reg);
                    written_reg  <= '0;
                    explored_reg <= 1'b0;
                    status_reg   <= 1'b0;
                end
                RES_UPDATE: begin
                    chosen_reg   <= '0;
                    written_reg  <= nq_reg;
                    explored_reg <= 1'b0;
                    status_reg   <= 1'b0;
                end
                default: begin
                    chosen_reg   <= '0;
                    written_reg  <= '0;
                    explored_reg <= 1'b0;
                    status_reg   <= 1'b1;
                end
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_chosen_action = chosen_reg;
    assign m_written_value = written_reg;
    assign m_explored      = explored_reg;
    assign m_status        = status_reg;

    a_load_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !(m_valid_reg && !m_ready))
        else $error("result word overwritten before it was taken");

    a_load_shows_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid_reg)
        else $error("loaded result word not presented");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmp_valid_reg |-> (32'(cmp_idx_reg) < 32'(na_eff)))
        else $error("scan compared an action beyond those in use");

    a_single_writer: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.clr_we && cmd.q_we))
        else $error("clearing pass and update write collide");

endmodule

### hdl/qtus_ctrl.sv
// Controller: sequences clearing, decode, table scan, update arithmetic and result hand-off.
module qtus_ctrl import qtus_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    res_kind_t   kind_reg;
    res_kind_t   kind_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            kind_reg  <= RES_REJECT;
        end else begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        kind_next  = kind_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (stat.clr_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                priority if (stat.env_bad) begin
                    state_next = ST_FINISH;
                    kind_next  = RES_REJECT;
                end else if (!stat.op_select) begin
                    if (stat.upd_bad) begin
                        state_next = ST_FINISH;
                        kind_next  = RES_REJECT;
                    end else begin
                        state_next = ST_SCAN;
                        kind_next  = RES_UPDATE;
                    end
                end else if (stat.sel_bad || stat.explore) begin
                    state_next = ST_FINISH;
                    kind_next  = RES_RANDOM;
                end else begin
                    state_next = ST_SCAN;
                    kind_next  = RES_GREEDY;
                end
            end
            ST_SCAN: begin
                if (stat.scan_last) begin
                    state_next = (kind_reg == RES_UPDATE) ? ST_CUR : ST_SEL_LAST;
                end
            end
            ST_CUR:      state_next = ST_MUL1;
            ST_SEL_LAST: state_next = ST_FINISH;
            ST_MUL1:     state_next = ST_SUM1;
            ST_SUM1:     state_next = ST_DIFF;
            ST_DIFF:     state_next = ST_MUL2;
            ST_MUL2:     state_next = ST_SUM2;
            ST_SUM2:     state_next = ST_FINISH;
            ST_FINISH: begin
                if (!stat.out_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd          = '0;
        cmd.res_kind = kind_reg;
        s_ready      = 1'b0;
        unique case (state_reg)
            ST_CLEAR: cmd.clr_we = 1'b1;
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
            end
            ST_DECODE: cmd.cnt_clr = 1'b1;
            ST_SCAN: begin
                cmd.rd_en   = 1'b1;
                cmd.cmp_en  = 1'b1;
                cmd.cnt_inc = 1'b1;
            end
            ST_CUR: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_cur = 1'b1;
            end
            ST_SEL_LAST: ;
            ST_MUL1: cmd.mul1 = 1'b1;
            ST_SUM1: cmd.sum1 = 1'b1;
            ST_DIFF: cmd.diff = 1'b1;
            ST_MUL2: cmd.mul2 = 1'b1;
            ST_SUM2: cmd.sum2 = 1'b1;
            ST_FINISH: begin
                // commit the write together with the result word
                cmd.out_load = !stat.out_busy;
                cmd.q_we     = !stat.out_busy && (kind_reg == RES_UPDATE);
            end
            default: ;
        endcase
    end

endmodule

### hdl/q_table_update_and_select.sv
// Top level: configuration registers and the controller/datapath pair of the Q-table engine.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------------------------
//  input    | s_valid / s_ready         | opcode, env, states, action, reward, randoms
//  result   | m_valid / m_ready         | chosen_action, written_value, explored, status
//  config   | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// One word in flight. Update: the next state is scanned through the single table read
// port, then two multiply/round/saturate steps form the new entry. Greedy select:
// the current state is scanned the same way. Explore, invalid state or rejected
// update: no table scan before the result.
// After reset the table is cleared one entry a cycle, all 8192 entries, before
// s_ready first rises; configuration writes are taken throughout.
// The result register frees the input side: a new word is taken while the last
// result waits; the final step stalls only if that result is still not taken.
module q_table_update_and_select import qtus_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_opcode,
    input  logic [ENV_W-1:0]         s_env_index,
    input  logic [STATE_W-1:0]       s_cur_state,
    input  logic [ACTION_W-1:0]      s_taken_action,
    input  logic [STATE_W-1:0]       s_following_state,
    input  logic signed [Q_W-1:0]    s_reward_value,
    input  logic [DRAW_W-1:0]        s_random_draw,
    input  logic [ACTION_W-1:0]      s_random_choice,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [ACTION_W-1:0]      m_chosen_action,
    output logic signed [Q_W-1:0]    m_written_value,
    output logic                     m_explored,
    output logic                     m_status,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data
);

    cfg_t     cfg_reg;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.grid_cols         <= GRID_W'(16);
            cfg_reg.grid_rows         <= GRID_W'(16);
            cfg_reg.actions_in_use    <= NACT_W'(4);
            cfg_reg.alpha_rate        <= FRAC_W'(6554);
            cfg_reg.discount          <= FRAC_W'(62259);
            cfg_reg.explore_threshold <= FRAC_W'(6554);
        end else if (cfg_valid && cfg_ready) begin
            // drop writes to unknown indexes
            unique case (cfg_index)
                CFG_GRID_WIDTH:  cfg_reg.grid_cols         <= cfg_data[GRID_W-1:0];
                CFG_GRID_HEIGHT: cfg_reg.grid_rows         <= cfg_data[GRID_W-1:0];
                CFG_ACTIONS:     cfg_reg.actions_in_use    <= cfg_data[NACT_W-1:0];
                CFG_LEARN_RATE:  cfg_reg.alpha_rate        <= cfg_data[FRAC_W-1:0];
                CFG_DISCOUNT:    cfg_reg.discount          <= cfg_data[FRAC_W-1:0];
                CFG_EXPLORE:     cfg_reg.explore_threshold <= cfg_data[FRAC_W-1:0];
                default: ;
            endcase
        end
    end

    qtus_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    qtus_dpath u_dpath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg               (cfg_reg),
        .cmd               (cmd),
        .stat              (stat),
        .s_opcode          (s_opcode),
        .s_env_index       (s_env_index),
        .s_cur_state       (s_cur_state),
        .s_taken_action    (s_taken_action),
        .s_following_state (s_following_state),
        .s_reward_value    (s_reward_value),
        .s_random_draw     (s_random_draw),
        .s_random_choice   (s_random_choice),
        .m_ready           (m_ready),
        .m_valid           (m_valid),
        .m_chosen_action   (m_chosen_action),
        .m_written_value   (m_written_value),
        .m_explored        (m_explored),
        .m_status          (m_status)
    );

endmodule
